// ----- design/assert_macros.svh -----
// Assertion macros shared by the renderer's RTL files.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in every cycle outside reset.
`define SSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define SSR_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication.
`define SSR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ----- design/ssr_pkg.sv -----
// Package for the scaled seven-segment renderer: widths, character codes
// and the segment table. No dependencies.
`default_nettype none

package ssr_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int MAX_SCALE  = 10;

  localparam int VALUE_W = 27;
  localparam int SCALE_W = 4;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Clamped scale, digit pitch (scale+3) and cell height (2*scale+3).
  localparam int S_W     = $clog2(MAX_SCALE + 1);
  localparam int PITCH_W = $clog2(MAX_SCALE + 4);
  localparam int HGT_W   = $clog2(2 * MAX_SCALE + 4);

  localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LEN_W       = $clog2(MAX_DIGITS + 1);
  localparam int LIM_W       = $clog2(MAX_DIGITS * (MAX_SCALE + 3) + 1);

  localparam int CMP_W  = (LIM_W > COL_W + 1) ? LIM_W : COL_W + 1;
  localparam int RCMP_W = (HGT_W > ROW_W) ? HGT_W : ROW_W;
  localparam int XCMP_W = (PITCH_W > COL_W) ? PITCH_W : COL_W;

  // Division by ten through a reciprocal, exact for any 32-bit dividend.
  localparam int          PROD_W     = VALUE_W + 32;
  localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int          RECIP_SHFT = 35;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_DASH  = 7'd45;
  localparam logic [CHAR_W-1:0] CH_BAR   = 7'd124;

  // Segment bits: 0 top, 1 upper left, 2 upper right, 3 middle,
  // 4 lower left, 5 lower right, 6 bottom.
  function automatic logic [6:0] seg_mask(input logic [DIGIT_W-1:0] digit);
    logic [6:0] m;
    case (digit)
      4'd0:    m = 7'h77;
      4'd1:    m = 7'h24;
      4'd2:    m = 7'h5D;
      4'd3:    m = 7'h6D;
      4'd4:    m = 7'h2E;
      4'd5:    m = 7'h6B;
      4'd6:    m = 7'h7B;
      4'd7:    m = 7'h25;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h6F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/ssr_query_if.sv -----
// Request channel of the renderer: number, scale and character position.
// Depends on ssr_pkg for the field widths.
`default_nettype none

interface ssr_query_if import ssr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] number_value;
  logic [SCALE_W-1:0] scale;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;

  modport source (output valid, number_value, scale, row, column, input ready);
  modport sink   (input valid, number_value, scale, row, column, output ready);
endinterface

`default_nettype wire

// ----- design/ssr_result_if.sv -----
// Result channel of the renderer: character code and frame flag.
// Depends on ssr_pkg for the field widths.
`default_nettype none

interface ssr_result_if import ssr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pixel_char;
  logic              inside_frame;

  modport source (output valid, pixel_char, inside_frame, input ready);
  modport sink   (input valid, pixel_char, inside_frame, output ready);
endinterface

`default_nettype wire

// ----- design/scaled_seven_segment_renderer.sv -----
// Scaled seven-segment renderer, top level. Uses ssr_pkg, ssr_query_if,
// ssr_result_if and assert_macros.svh.
// Throughput one request per cycle while the result side does not stall, set by the
// one-digit-per-stage decimal conversion. Synchronous reset empties every stage;
// no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module scaled_seven_segment_renderer import ssr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  ssr_query_if.sink    query,
  ssr_result_if.source result
);

  // Stage map. Stage 0 registers the request and clamps the scale. Each of
  // the next MAX_DIGITS stages peels off one decimal digit with a reciprocal
  // multiply; the first of them also finds the digit cell under the column,
  // and the second the column offset within that cell. After the digits are
  // known, one stage finds the number's length, the frame test and the
  // segment mask of the addressed digit, and the last stage picks the
  // character. The last stage is the output register.
  localparam int CELL_STG = 1;
  localparam int X_STG    = 2;
  localparam int LEN_STG  = MAX_DIGITS + 1;
  localparam int CHR_STG  = MAX_DIGITS + 2;
  localparam int NSTG     = MAX_DIGITS + 3;

  typedef struct packed {
    logic [VALUE_W-1:0]                   value;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]   digits;
    logic [S_W-1:0]                       s;
    logic [ROW_W-1:0]                     row;
    logic [COL_W-1:0]                     col;
    logic [DIGIT_IDX_W-1:0]               cell_idx;
    logic [COL_W-1:0]                     base;
    logic [COL_W-1:0]                     x;
    logic [6:0]                           mask;
    logic                                 in_frame;
    logic [CHAR_W-1:0]                    ch;
  } pipe_t;

  pipe_t           pipe [NSTG];
  pipe_t           nxt  [NSTG];
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   adv;

  // A stage takes new contents when it is empty or when its contents move
  // on, so bubbles close up and a stall at the output loses nothing.
  assign adv[NSTG] = result.ready;
  generate
    for (genvar g = 0; g < NSTG; g++) begin : g_adv
      assign adv[g] = !vld[g] || adv[g+1];
    end
  endgenerate

  assign query.ready         = adv[0];
  assign result.valid        = vld[NSTG-1];
  assign result.pixel_char   = pipe[NSTG-1].ch;
  assign result.inside_frame = pipe[NSTG-1].in_frame;

  // Stage 0: capture the request and bring the scale into range.
  always_comb begin
    nxt[0]        = '0;
    nxt[0].value  = query.number_value;
    nxt[0].row    = query.row;
    nxt[0].col    = query.column;
    if (query.scale == '0) begin
      nxt[0].s = S_W'(1);
    end else if (int'(query.scale) > MAX_SCALE) begin
      nxt[0].s = S_W'(MAX_SCALE);
    end else begin
      nxt[0].s = S_W'(query.scale);
    end
  end

  generate
    for (genvar g = 1; g < NSTG; g++) begin : g_stage
      always_comb begin
        logic [PROD_W-1:0]      prod;
        logic [VALUE_W-1:0]     q;
        logic [VALUE_W-1:0]     q10;
        logic [PITCH_W-1:0]     pitch;
        logic [LIM_W-1:0]       prod_k;
        logic [LIM_W-1:0]       lim;
        logic [LEN_W-1:0]       len;
        logic [DIGIT_IDX_W-1:0] idx;
        logic [HGT_W-1:0]       hgt;
        logic [RCMP_W-1:0]      r;
        logic [RCMP_W-1:0]      rs;
        logic [RCMP_W-1:0]      rh;
        logic [XCMP_W-1:0]      xv;
        logic [XCMP_W-1:0]      xs;

        nxt[g] = pipe[g-1];
        pitch  = PITCH_W'(pipe[g-1].s) + PITCH_W'(3);
        hgt    = (HGT_W'(pipe[g-1].s) << 1) + HGT_W'(3);
        prod   = '0;
        q      = '0;
        q10    = '0;
        prod_k = '0;
        lim    = '0;
        len    = '0;
        idx    = '0;
        r      = RCMP_W'(pipe[g-1].row);
        rs     = RCMP_W'(pipe[g-1].s);
        rh     = RCMP_W'(hgt);
        xv     = XCMP_W'(pipe[g-1].x);
        xs     = XCMP_W'(pipe[g-1].s);

        // One decimal digit per stage: q = v / 10, digit = v - 10*q.
        if (g <= MAX_DIGITS) begin
          prod  = PROD_W'(pipe[g-1].value) * PROD_W'(RECIP_TEN);
          q     = VALUE_W'(prod >> RECIP_SHFT);
          q10   = (q << 3) + (q << 1);
          nxt[g].value = q;
          nxt[g].digits[DIGIT_IDX_W'(g-1)] = DIGIT_W'(pipe[g-1].value - q10);
        end

        // Cell under the column: how many whole pitches lie at or below it.
        if (g == CELL_STG) begin
          nxt[g].cell_idx = '0;
          nxt[g].base     = '0;
          for (int k = 1; k < MAX_DIGITS; k++) begin
            prod_k = LIM_W'(k) * LIM_W'(pitch);
            if (CMP_W'(pipe[g-1].col) >= CMP_W'(prod_k)) begin
              nxt[g].cell_idx = DIGIT_IDX_W'(k);
              nxt[g].base     = COL_W'(prod_k);
            end
          end
        end

        if (g == X_STG) begin
          nxt[g].x = pipe[g-1].col - pipe[g-1].base;
        end

        // Length without leading zeros, frame test and the addressed digit.
        if (g == LEN_STG) begin
          len = LEN_W'(1);
          for (int j = 0; j < MAX_DIGITS; j++) begin
            if (pipe[g-1].digits[j] != '0) begin
              len = LEN_W'(j + 1);
            end
          end
          lim = LIM_W'(len) * LIM_W'(pitch);
          nxt[g].in_frame = (r < rh) &&
                            (CMP_W'(pipe[g-1].col) + CMP_W'(1) < CMP_W'(lim));
          idx = DIGIT_IDX_W'(len - LEN_W'(1) - LEN_W'(pipe[g-1].cell_idx));
          // The separator column after each cell carries no segment.
          if (xv == xs + XCMP_W'(2)) begin
            nxt[g].mask = '0;
          end else begin
            nxt[g].mask = seg_mask(pipe[g-1].digits[idx]);
          end
        end

        if (g == CHR_STG) begin
          nxt[g].ch = CH_SPACE;
          if (pipe[g-1].in_frame) begin
            if ((xv != '0) && (xv <= xs)) begin
              if (((r == '0) && pipe[g-1].mask[0]) ||
                  ((r == rs + RCMP_W'(1)) && pipe[g-1].mask[3]) ||
                  ((r == rh - RCMP_W'(1)) && pipe[g-1].mask[6])) begin
                nxt[g].ch = CH_DASH;
              end
            end else if ((r != '0) && (r <= rs)) begin
              if (((xv == '0) && pipe[g-1].mask[1]) ||
                  ((xv == xs + XCMP_W'(1)) && pipe[g-1].mask[2])) begin
                nxt[g].ch = CH_BAR;
              end
            end else if ((r >= rs + RCMP_W'(2)) && (r < rh - RCMP_W'(1))) begin
              if (((xv == '0) && pipe[g-1].mask[4]) ||
                  ((xv == xs + XCMP_W'(1)) && pipe[g-1].mask[5])) begin
                nxt[g].ch = CH_BAR;
              end
            end
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= query.valid;
      end
      for (int g = 1; g < NSTG; g++) begin
        if (adv[g]) begin
          vld[g] <= vld[g-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NSTG; g++) begin
      if (adv[g]) begin
        pipe[g] <= nxt[g];
      end
    end
  end

  `SSR_ASSERT_IMP(a_space_outside, result.valid && !result.inside_frame, result.pixel_char == CH_SPACE, "character outside the frame is not a space")
  `SSR_ASSERT_IMP(a_char_code, result.valid, (result.pixel_char == CH_SPACE) || (result.pixel_char == CH_DASH) || (result.pixel_char == CH_BAR), "unexpected character code")
  `SSR_ASSERT_IMP(a_scale_clamped, vld[0], (pipe[0].s != '0) && (int'(pipe[0].s) <= MAX_SCALE), "scale left the clamped range")
  `SSR_ASSERT_NEXT(a_first_stage_holds, vld[0] && !adv[0], vld[0] && $stable(pipe[0].value), "stalled first stage lost its request")
  `SSR_ASSERT_IMP(a_ready_when_empty, !vld[0], query.ready, "empty first stage refused a request")

endmodule

`default_nettype wire

// ----- tb/ssr_pixel_checker.sv -----
// Checker for the seven-segment renderer: watches both channels, predicts each pixel
// from its request and compares it with the result that comes back in order.
// Depends on ssr_pkg, ssr_query_if and ssr_result_if.
`timescale 1ns / 100ps

module ssr_pixel_checker import ssr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ssr_query_if      query,
  ssr_result_if     result,
  output int        pending_pixels,
  output int        errors
);

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_char;
    logic              inside_frame;
  } pixel_t;

  localparam int SEG_TOP = 0;
  localparam int SEG_UL  = 1;
  localparam int SEG_UR  = 2;
  localparam int SEG_MID = 3;
  localparam int SEG_LL  = 4;
  localparam int SEG_LR  = 5;
  localparam int SEG_BOT = 6;

  localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
    7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
  };

  pixel_t expected_pixels [$];

  // Character at one raster position of the number drawn at the given scale.
  function automatic pixel_t render_char(input logic [VALUE_W-1:0] number,
                                         input logic [SCALE_W-1:0] scale_in,
                                         input logic [ROW_W-1:0]   row,
                                         input logic [COL_W-1:0]   col);
    int unsigned value, s, len, height, width, cell_no, x;
    logic [3:0]  digit [MAX_DIGITS];
    logic [6:0]  segs;
    pixel_t      px;
    value           = number;
    s               = scale_in;
    len             = 1;
    px.pixel_char   = CH_SPACE;
    px.inside_frame = 1'b0;
    if (s == 0) s = 1;
    if (s > MAX_SCALE) s = MAX_SCALE;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digit[i] = 4'(value % 10);
      value    = value / 10;
      if (digit[i] != 0) len = i + 1;
    end
    height = 2 * s + 3;
    width  = len * (s + 3) - 1;
    if (row < height && col < width) begin
      px.inside_frame = 1'b1;
      cell_no = col / (s + 3);
      x       = col % (s + 3);
      if (x != s + 2 && cell_no < len) begin
        segs = DIGIT_SEGMENTS[digit[len - 1 - cell_no]];
        if (x >= 1 && x <= s) begin
          if ((row == 0 && segs[SEG_TOP]) || (row == s + 1 && segs[SEG_MID]) ||
              (row == height - 1 && segs[SEG_BOT]))
            px.pixel_char = CH_DASH;
        end else if (row >= 1 && row <= s) begin
          if ((x == 0 && segs[SEG_UL]) || (x == s + 1 && segs[SEG_UR]))
            px.pixel_char = CH_BAR;
        end else if (row >= s + 2 && row < height - 1) begin
          if ((x == 0 && segs[SEG_LL]) || (x == s + 1 && segs[SEG_LR]))
            px.pixel_char = CH_BAR;
        end
      end
    end
    return px;
  endfunction

  initial begin
    pending_pixels = 0;
    errors         = 0;
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      // Results are retired before new requests are queued, so a result
      // in the very cycle of its request is still reported as unexpected.
      if (result.valid && result.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_char %0d, inside_frame %0d",
                 result.pixel_char, result.inside_frame);
          errors = errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (result.pixel_char !== want.pixel_char) begin
            $error("pixel_char: expected %0d, got %0d", want.pixel_char, result.pixel_char);
            errors = errors + 1;
          end
          if (result.inside_frame !== want.inside_frame) begin
            $error("inside_frame: expected %0d, got %0d",
                   want.inside_frame, result.inside_frame);
            errors = errors + 1;
          end
        end
      end
      if (query.valid && query.ready)
        expected_pixels.push_back(render_char(query.number_value, query.scale,
                                              query.row, query.column));
      pending_pixels = expected_pixels.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the renderer testbench: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Depends on ssr_pkg, both channel interfaces and ssr_pixel_checker.
`timescale 1ns / 100ps

module testbench import ssr_pkg::*; ();

  // Cycles without any handshake before the run is declared hung. The slowest
  // correct request waits out a long sender gap, the pipeline and a long
  // receiver stall, which together stay well within this limit.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last result, a multiple of the pipeline depth.
  localparam int TAIL_CYCLES    = 3 * (MAX_DIGITS + 3);
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 200;

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;
  int   pending_pixels;
  int   errors;
  int   idle_cycles;

  ssr_query_if  query_ch ();
  ssr_result_if result_ch ();

  scaled_seven_segment_renderer u_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  ssr_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .query          (query_ch),
    .result         (result_ch),
    .pending_pixels (pending_pixels),
    .errors         (errors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly no delay or a short one, and now and then a long one, so that
  // gaps land on every stage of the pipeline.
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one request after a random gap and holds it until it is taken.
  // Inputs change on the falling edge; ready is looked at on the rising edge.
  task automatic send_query(input logic [VALUE_W-1:0] number,
                            input logic [SCALE_W-1:0] scale,
                            input logic [ROW_W-1:0]   row,
                            input logic [COL_W-1:0]   column);
    int unsigned gap;
    gap = no_idle ? 0 : pick_delay();
    if (gap != 0) begin
      @(negedge clk);
      query_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    query_ch.valid        <= 1'b1;
    query_ch.number_value <= number;
    query_ch.scale        <= scale;
    query_ch.row          <= row;
    query_ch.column       <= column;
    do @(posedge clk); while (!query_ch.ready);
  endtask

  // The sender stops until every outstanding pixel has come back.
  task automatic drain_pipeline();
    @(negedge clk);
    query_ch.valid <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
  endtask

  // A random request shaped so that most positions fall inside the frame of
  // a number of random length; the rest use the whole range of every field,
  // which also covers the upper bits of the value, scale, row and column.
  task automatic random_query();
    int unsigned ndigits, low_bound, value, len, s, height, width;
    logic [VALUE_W-1:0] number;
    logic [SCALE_W-1:0] scale;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    if ($urandom_range(0, 9) == 0) begin
      number = $urandom_range(0, (1 << VALUE_W) - 1);
    end else begin
      ndigits   = $urandom_range(1, MAX_DIGITS);
      low_bound = 1;
      repeat (ndigits - 1) low_bound = low_bound * 10;
      number = $urandom_range(ndigits == 1 ? 0 : low_bound, low_bound * 10 - 1);
    end
    scale = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
    // Frame size as the renderer will see it, to aim the position.
    s = (scale == 0) ? 1 : ((scale > MAX_SCALE) ? MAX_SCALE : scale);
    value = number;
    len   = 1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (value % 10 != 0) len = i + 1;
      value = value / 10;
    end
    height = 2 * s + 3;
    width  = len * (s + 3) - 1;
    row    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : $urandom_range(0, height);
    column = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(0, width);
    send_query(number, scale, row, column);
  endtask

  // Receiver side: runs of ready with random stalls between them, none at
  // all while a no-idling phase is under way.
  initial begin
    int unsigned run_len, stall_len;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      run_len   = $urandom_range(1, 20);
      stall_len = no_idle ? 0 : pick_delay();
      repeat (run_len) begin
        @(negedge clk);
        result_ch.ready <= 1'b1;
      end
      repeat (stall_len) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
    end
  end

  // Any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    no_idle               = 1'b0;
    idle_cycles           = 0;
    rst                   = 1'b1;
    query_ch.valid        = 1'b0;
    query_ch.number_value = '0;
    query_ch.scale        = '0;
    query_ch.row          = '0;
    query_ch.column       = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed requests: the single zero digit, its corners and both edges
    // of the frame, segments that several digits leave dark, the widest frame
    // with a separator column, clamped and zero scales, values with more
    // than eight digits, and leading-zero suppression.
    send_query(0, 1, 0, 1);
    send_query(0, 1, 2, 1);
    send_query(0, 1, 1, 2);
    send_query(0, 1, 0, 0);
    send_query(0, 1, 0, 3);
    send_query(0, 1, 5, 0);
    send_query(12345678, 1, 4, 1);
    send_query(12345678, 1, 2, 9);
    send_query(90, 3, 4, 2);
    send_query(99999999, 10, 22, 102);
    send_query(99999999, 10, 11, 12);
    send_query(99999999, 10, 10, 0);
    send_query(88888888, 11, 21, 1);
    send_query(88888888, 15, 22, 100);
    send_query((1 << VALUE_W) - 1, 15, 31, 127);
    send_query((1 << VALUE_W) - 1, 0, 1, 0);
    send_query(100000000, 2, 3, 0);
    send_query(10000000, 1, 0, 1);
    send_query(10000000, 1, 0, 29);
    send_query(7, 1, 4, 1);
    send_query(4, 2, 0, 1);
    send_query(6, 2, 1, 3);
    send_query(2, 2, 4, 3);
    send_query(5, 2, 2, 0);
    drain_pipeline();

    // Random phases; every third one runs back to back on both sides, and
    // the sender empties the pipeline between phases.
    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p % 3 == 1);
      repeat (PHASE_REQUESTS) random_query();
      drain_pipeline();
    end
    no_idle = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ssr_pkg.sv
design/ssr_query_if.sv
design/ssr_result_if.sv
design/scaled_seven_segment_renderer.sv
tb/ssr_pixel_checker.sv
tb/testbench.sv
